### hdl/skinning_matrix_blend_macros.svh
// Assertion macros for the skinning matrix blend block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SKINNING_MATRIX_BLEND_MACROS_SVH
`define SKINNING_MATRIX_BLEND_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SMB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/smb_pkg.sv
// Shared constants, command type and saturation helper for the skinning blend.
// No dependencies.
`default_nettype none

package smb_pkg;

    localparam int JOINT_COUNT = 256;
    localparam int JOINT_AW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int ELEM_COUNT  = 16;
    localparam int MEM_DEPTH   = JOINT_COUNT * ELEM_COUNT;
    localparam int MEM_AW      = JOINT_AW + 4;
    localparam int CMDQ_AW     = 1;
    localparam int CMDQ_DEPTH  = 2 ** CMDQ_AW;

    // Item kind, coded as the input mode field
    typedef enum logic [1:0] {
        CMD_LOAD_T = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RIGID  = 2'd2,
        CMD_INFL   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [JOINT_AW-1:0]   joint;
        logic                  in_range;
        logic [3:0]            elem;
        logic signed [31:0]    value;
        logic [15:0]           weight;
        logic                  last;
    } t_cmd;

    // Clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            return -32'sh8000_0000;
        end
        return $signed(x[31:0]);
    endfunction

endpackage

`default_nettype wire

### hdl/smb_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`default_nettype none

interface smb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         joint_index;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [15:0]        weight;
    logic               last_influence;

    modport source (output valid, mode, joint_index, element_index, element_value,
                    weight, last_influence, input ready);
    modport sink   (input valid, mode, joint_index, element_index, element_value,
                    weight, last_influence, output ready);
endinterface

interface smb_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               last_element;

    modport source (output valid, out_index, out_value, last_element, input ready);
    modport sink   (input valid, out_index, out_value, last_element, output ready);
endinterface

`default_nettype wire

### hdl/skinning_matrix_blend.sv
// Top level of the skinning matrix blend: front end, command queue, back end.
// Depends on smb_pkg, smb_ifs, smb_front, smb_back and the macros header.
//
// Usage:
//   i_item carries load, rigid and influence items (valid/ready); o_result
//   carries matrix elements in order 0..15, last_element set on element 15.
//   Items enter a two-entry command queue, so the input is taken while the
//   back end works or while a result waits for the receiver.
//   Load items are written to the stores as the back end takes them.
//   A rigid item emits 16 elements, read in turn from the transform store
//   read port. An influence item runs 64 multiply-accumulates through the
//   one shared 32x32 multiplier, one per cycle, through five pipeline stages.
//   The last influence then emits the accumulator element by element.
//   A stalled receiver holds the output register; the back end waits before
//   the next element, while the queue keeps taking input until full.
//   Reset (synchronous, active low) empties the queue, zeroes the accumulator
//   and drops o_result.valid; matrix stores are not cleared and need loading.
`default_nettype none

module skinning_matrix_blend (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smb_in_if.sink    i_item,
    smb_out_if.source o_result
);
    import smb_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    smb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    smb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .o_result    (o_result)
    );

    `include "skinning_matrix_blend_macros.svh"

    `SMB_ASSERT_SAME(a_last_on_fifteen, o_result.valid && o_result.last_element, o_result.out_index == 4'd15, "last_element off element 15")
    `SMB_ASSERT_SAME(a_full_has_cmd, !i_item.ready, w_cmd_valid, "input stalled with empty queue")
    `SMB_ASSERT_NEXT(a_cmd_held, w_cmd_valid && !w_cmd_ready, w_cmd_valid, "queued command lost")

endmodule

`default_nettype wire

### hdl/smb_front.sv
// Front end: accepts input items, classifies them into commands, queues them.
// Depends on smb_pkg and smb_in_if.
`default_nettype none

module smb_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    smb_in_if.sink         i_item,
    output smb_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  wire logic      i_cmd_ready
);
    import smb_pkg::*;

    t_cmd                r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wr_ptr;
    logic [CMDQ_AW-1:0]  r_rd_ptr;
    logic [CMDQ_AW:0]    r_count;
    t_cmd                w_cmd;
    logic                w_push;
    logic                w_pop;

    // Classify the incoming item
    always_comb begin
        w_cmd.kind     = t_cmd_kind'(i_item.mode);
        w_cmd.joint    = JOINT_AW'(i_item.joint_index);
        w_cmd.in_range = 32'(i_item.joint_index) < JOINT_COUNT;
        w_cmd.elem     = i_item.element_index;
        w_cmd.value    = i_item.element_value;
        w_cmd.weight   = i_item.weight;
        w_cmd.last     = i_item.last_influence;
    end

    assign i_item.ready = r_count < (CMDQ_AW+1)'(CMDQ_DEPTH);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid  = r_count != '0;
    assign o_cmd        = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/smb_back.sv
// Back end: matrix stores, shared multiply-accumulate pipeline, accumulator, output.
// Depends on smb_pkg and smb_out_if.
`default_nettype none

module smb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire smb_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    smb_out_if.source           o_result
);
    import smb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    logic signed [31:0] r_mem_t [MEM_DEPTH];
    logic signed [31:0] r_mem_b [MEM_DEPTH];
    logic signed [31:0] r_acc   [ELEM_COUNT];

    t_state             r_state;
    t_cmd               r_cmd;
    logic [5:0]         r_cnt;
    logic [3:0]         r_ecnt;
    logic               r_pend;

    logic signed [31:0] r_rd_t;
    logic signed [31:0] r_rd_b;
    logic               r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [1:0]         r_s1_k, r_s2_k;
    logic [3:0]         r_s1_e, r_s2_e, r_s3_e, r_s4_e;
    logic signed [63:0] r_prod;
    logic signed [49:0] r_sum;
    logic signed [48:0] r_wprod;

    logic               r_ov;
    logic [3:0]         r_oidx;
    logic signed [31:0] r_oval;
    logic               r_olast;

    logic               w_pop;
    logic               w_we_t, w_we_b;
    logic [MEM_AW-1:0]  w_wa;
    logic [MEM_AW-1:0]  w_ra_t, w_ra_b;
    logic signed [63:0] w_rnd;
    logic signed [47:0] w_term;
    logic signed [31:0] w_sum_sat;
    logic signed [63:0] w_t64;
    logic signed [31:0] w_t32;
    logic signed [31:0] w_acc_new;
    logic               w_issue;
    logic               w_out_free;
    logic signed [31:0] w_emit_val;

    assign o_cmd_ready = r_state == S_IDLE;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_we_t      = w_pop && i_cmd.kind == CMD_LOAD_T && i_cmd.in_range;
    assign w_we_b      = w_pop && i_cmd.kind == CMD_LOAD_B && i_cmd.in_range;
    assign w_wa        = {i_cmd.joint, i_cmd.elem};

    // Read addresses: T[r][k] and B[k][c] during MAC, T[n] while emitting
    always_comb begin
        if (r_state == S_EMIT) begin
            w_ra_t = {r_cmd.joint, r_ecnt};
        end else begin
            w_ra_t = {r_cmd.joint, r_cnt[5:4], r_cnt[1:0]};
        end
        w_ra_b = {r_cmd.joint, r_cnt[1:0], r_cnt[3:2]};
    end

    // Stores
    always_ff @(posedge i_clk) begin
        if (w_we_t) begin
            r_mem_t[w_wa] <= i_cmd.value;
        end
        r_rd_t <= r_mem_t[w_ra_t];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[w_wa] <= i_cmd.value;
        end
        r_rd_b <= r_mem_b[w_ra_b];
    end

    // Datapath arithmetic
    always_comb begin
        w_rnd     = (r_prod + 64'sd32768) >>> 16;
        w_term    = r_cmd.in_range ? $signed(w_rnd[47:0]) : 48'sd0;
        w_sum_sat = sat32(64'(r_sum));
        w_t64     = (64'(r_wprod) + 64'sd16384) >>> 15;
        w_t32     = sat32(w_t64);
        w_acc_new = sat32(64'(r_acc[r_s4_e]) + 64'(w_t32));
    end

    // Product pipeline
    always_ff @(posedge i_clk) begin
        r_prod  <= r_rd_t * r_rd_b;
        if (r_s2_v) begin
            r_sum <= (r_s2_k == 2'd0) ? 50'(w_term) : r_sum + 50'(w_term);
        end
        if (r_s3_v) begin
            r_wprod <= $signed({1'b0, r_cmd.weight}) * w_sum_sat;
        end
        r_s1_k <= r_cnt[1:0];
        r_s1_e <= r_cnt[5:2];
        r_s2_k <= r_s1_k;
        r_s2_e <= r_s1_e;
        r_s3_e <= r_s2_e;
        r_s4_e <= r_s3_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= r_state == S_MAC;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v && r_s2_k == 2'd3;
            r_s4_v <= r_s3_v;
        end
    end

    // Emit path
    assign w_out_free = !r_ov || o_result.ready;
    assign w_issue    = r_state == S_EMIT && !r_pend && w_out_free;
    assign w_emit_val = (r_cmd.kind == CMD_RIGID) ?
                        (r_cmd.in_range ? r_rd_t : 32'sd0) : r_acc[r_ecnt];

    // Accumulator: updated by the last stage, cleared as it is emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ELEM_COUNT; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_s4_v) begin
            r_acc[r_s4_e] <= w_acc_new;
        end else if (r_pend && r_cmd.kind == CMD_INFL) begin
            r_acc[r_ecnt] <= '0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ecnt  <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_cnt  <= '0;
                        r_ecnt <= '0;
                        case (i_cmd.kind)
                            CMD_RIGID: r_state <= S_EMIT;
                            CMD_INFL:  r_state <= S_MAC;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_s4_v && r_s4_e == 4'd15) begin
                        r_state <= r_cmd.last ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_issue) begin
                        r_pend <= 1'b1;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                        r_ecnt <= r_ecnt + 1'b1;
                        if (r_ecnt == 4'd15) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_pend) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_oidx  <= r_ecnt;
            r_oval  <= w_emit_val;
            r_olast <= r_ecnt == 4'd15;
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.out_index    = r_oidx;
    assign o_result.out_value    = r_oval;
    assign o_result.last_element = r_olast;

endmodule

`default_nettype wire

### tb/tb_skinning_matrix_blend.sv
// Self-checking bench for skinning_matrix_blend: random loads, rigid and blend items.
// Depends on smb_pkg and smb_ifs; predicts each emitted matrix and compares per element.
`default_nettype none

module tb_skinning_matrix_blend;
    timeunit 1ns;
    timeprecision 1ps;
    import smb_pkg::*;

    typedef struct {
        t_cmd_kind   kind;
        logic [7:0]  joint;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [15:0] weight;
        logic        last;
    } t_item;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        last;
    } t_elem;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    smb_in_if  item_if ();
    smb_out_if res_if ();

    skinning_matrix_blend u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source)
    );

    t_item pending_items[$];
    t_elem matrix_elems[$];
    logic [31:0] xform_mem [JOINT_COUNT*16];
    logic [31:0] ibind_mem [JOINT_COUNT*16];
    logic signed [31:0] blend_acc [16];
    int  err_count = 0;
    int  cycle_count = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  stim_done = 0;
    // joints 0 and 1 get fully written first; only those are read in range
    int  loaded_joints = 2;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] rd_mem(bit ibind, logic [7:0] j, int e);
        if (j >= JOINT_COUNT) return 0;
        return ibind ? ibind_mem[j*16+e] : xform_mem[j*16+e];
    endfunction

    // Append one item to the stimulus list
    task automatic add_item(t_item it);
        pending_items = {pending_items, it};
    endtask

    // Push the sixteen elements of a matrix onto the expected list
    task automatic queue_matrix(logic signed [31:0] m [16]);
        t_elem r;
        for (int e = 0; e < 16; e++) begin
            r.idx = 4'(e);
            r.value = m[e];
            r.last = (e == 15);
            matrix_elems = {matrix_elems, r};
        end
    endtask

    // Predict the effect of one accepted item
    task automatic predict_blend(t_item it);
        logic signed [31:0] m [16];
        logic signed [63:0] a, b, sum, t;
        case (it.kind)
            CMD_LOAD_T: if (it.joint < JOINT_COUNT) xform_mem[it.joint*16+it.elem] = it.value;
            CMD_LOAD_B: if (it.joint < JOINT_COUNT) ibind_mem[it.joint*16+it.elem] = it.value;
            CMD_RIGID: begin
                for (int e = 0; e < 16; e++) m[e] = rd_mem(1'b0, it.joint, e);
                queue_matrix(m);
            end
            default: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        sum = 0;
                        for (int k = 0; k < 4; k++) begin
                            a = rd_mem(1'b0, it.joint, r*4+k);
                            b = rd_mem(1'b1, it.joint, k*4+c);
                            sum += (a * b + 64'sd32768) >>> 16;
                        end
                        t = ($signed({48'd0, it.weight}) * clamp32(sum) + 64'sd16384) >>> 15;
                        blend_acc[r*4+c] = clamp32(64'(blend_acc[r*4+c]) + clamp32(t));
                    end
                end
                if (it.last) begin
                    m = blend_acc;
                    for (int e = 0; e < 16; e++) blend_acc[e] = 0;
                    queue_matrix(m);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic t_item mk(t_cmd_kind k, logic [7:0] j, logic [3:0] e,
                                 logic [31:0] v, logic [15:0] w, logic l);
        t_item it;
        it.kind = k; it.joint = j; it.elem = e; it.value = v; it.weight = w; it.last = l;
        return it;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        endcase
    endfunction

    function automatic logic [15:0] rand_wt();
        case ($urandom_range(0, 4))
            0: return 16'd32768;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Joint for reads: loaded joints or out of range, never unwritten entries
    function automatic logic [7:0] rd_joint();
        if (JOINT_COUNT < 256 && $urandom_range(0, 9) == 0)
            return 8'($urandom_range(JOINT_COUNT, 255));
        return 8'($urandom_range(0, loaded_joints - 1));
    endfunction

    // Out-of-range joint where the index field can reach one, else the last loaded joint
    function automatic logic [7:0] far_joint();
        return (JOINT_COUNT < 256) ? 8'(JOINT_COUNT) : 8'(loaded_joints - 1);
    endfunction

    // Driver
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || item_if.ready) begin
            if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
                item_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                item_if.valid          <= 1'b1;
                item_if.mode           <= it.kind;
                item_if.joint_index    <= it.joint;
                item_if.element_index  <= it.elem;
                item_if.element_value  <= it.value;
                item_if.weight         <= it.weight;
                item_if.last_influence <= it.last;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        res_if.ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_item it;
        t_elem w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            it = mk(t_cmd_kind'(item_if.mode), item_if.joint_index, item_if.element_index,
                    item_if.element_value, item_if.weight, item_if.last_influence);
            predict_blend(it);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (matrix_elems.size() == 0) begin
                report_mismatch("unexpected element", 32'(res_if.out_index), 32'd0);
            end else begin
                w = matrix_elems.pop_front();
                if (res_if.out_index !== w.idx)
                    report_mismatch("out_index", 32'(res_if.out_index), 32'(w.idx));
                if (res_if.out_value !== w.value)
                    report_mismatch("out_value", res_if.out_value, w.value);
                if (res_if.last_element !== w.last)
                    report_mismatch("last_element", 32'(res_if.last_element), 32'(w.last));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycle_count > 2000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || item_if.valid || matrix_elems.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Random phase: mostly well-formed envelopes, some loads and rigid items
    task automatic random_phase(int n);
        int cnt;
        int j;
        cnt = 0;
        while (cnt < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    j = $urandom_range(0, 255);
                    if (j >= loaded_joints && j < JOINT_COUNT)
                        j = $urandom_range(0, loaded_joints - 1);
                    add_item(mk($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_T, 8'(j),
                                4'($urandom), rand_val(), 16'($urandom), 1'($urandom)));
                    cnt++;
                end
                2: begin
                    add_item(mk(CMD_RIGID, rd_joint(), 4'($urandom), 32'($urandom),
                                16'($urandom), 1'($urandom)));
                    cnt++;
                end
                default: begin
                    int len;
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        add_item(mk(CMD_INFL, rd_joint(), 4'($urandom), 32'($urandom),
                                    rand_wt(), i == len - 1));
                    cnt += len;
                end
            endcase
        end
    endtask

    initial begin
        int ph [4][2];
        ph = '{'{0, 0}, '{75, 0}, '{0, 75}, '{29, 29}};
        item_if.valid = 1'b0;
        item_if.mode = CMD_LOAD_T;
        item_if.joint_index = '0;
        item_if.element_index = '0;
        item_if.element_value = '0;
        item_if.weight = '0;
        item_if.last_influence = 1'b0;
        res_if.ready = 1'b0;
        for (int e = 0; e < 16; e++) blend_acc[e] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the loaded joints; joint 0 identity, the rest random with extremes
        for (int j = 0; j < loaded_joints; j++)
            for (int e = 0; e < 16; e++) begin
                add_item(mk(CMD_LOAD_T, 8'(j), 4'(e),
                    j == 0 ? ((e % 5 == 0) ? 32'h0001_0000 : 32'h0) : rand_val(),
                    16'($urandom), 1'($urandom)));
                add_item(mk(CMD_LOAD_B, 8'(j), 4'(e),
                    j == 0 ? ((e % 5 == 0) ? 32'h0001_0000 : 32'h0) : rand_val(),
                    16'($urandom), 1'($urandom)));
            end

        // Directed items
        add_item(mk(CMD_LOAD_T, far_joint(), 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        add_item(mk(CMD_RIGID, 8'd0, 4'd0, 32'd0, 16'd0, 1'b0));
        add_item(mk(CMD_RIGID, far_joint(), 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        add_item(mk(CMD_INFL, 8'd0, 4'd0, 32'd0, 16'd32768, 1'b1));
        add_item(mk(CMD_INFL, 8'd1, 4'd0, 32'd0, 16'hFFFF, 1'b0));
        add_item(mk(CMD_RIGID, 8'd1, 4'd0, 32'd0, 16'd0, 1'b0));
        add_item(mk(CMD_INFL, 8'd1, 4'd0, 32'd0, 16'hFFFF, 1'b1));
        add_item(mk(CMD_INFL, far_joint(), 4'd0, 32'd0, 16'd32768, 1'b0));
        add_item(mk(CMD_INFL, 8'd1, 4'd0, 32'd0, 16'd0, 1'b0));
        add_item(mk(CMD_INFL, 8'd0, 4'd0, 32'd0, 16'd16384, 1'b1));
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle = ph[p][0];
            recv_stall = ph[p][1];
            random_phase(12);
            wait_drained();
        end
        send_idle = 0;
        recv_stall = 0;

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
